@@ sv/pseudocolor_pixel_mapper_defines.svh @@
// Assertion macros shared by the pseudocolor pixel mapper RTL.
// Both macros expect aclk, and PPM_ASSERT also aresetn, to be in scope at the point of use.
`ifndef PSEUDOCOLOR_PIXEL_MAPPER_DEFINES_SVH
`define PSEUDOCOLOR_PIXEL_MAPPER_DEFINES_SVH

// Checked only while out of reset.
`define PPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/ppm_pkg.sv @@
// Shared types and constants for the pseudocolor pixel mapper.
// No dependencies.
package ppm_pkg;

    localparam int PIX_W   = 32;
    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [PIX_W-1:0] LOW_RESET  = 32'sd0;
    localparam logic signed [PIX_W-1:0] HIGH_RESET = 32'sd1792;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW     = 2'd0,
        CFG_HIGH    = 2'd1,
        CFG_REVERSE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] high_value;
        logic [PIX_W-1:0] span;       // high - low, valid when span_ok
        logic             span_ok;
        logic             reverse;
    } cfg_t;

    typedef struct packed {
        logic black;
        logic at_max;
        logic clamp_lo;
        logic clamp_hi;
    } ctl_t;

endpackage

@@ sv/ppm_cfg_regs.sv @@
// Configuration register file and span precompute for the pixel mapper.
// Depends on ppm_pkg.
module ppm_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppm_pkg::PIX_W-1:0]           cfg_data,
    output ppm_pkg::cfg_t                       cfg
);

    logic [ppm_pkg::PIX_W-1:0] low_reg;
    logic [ppm_pkg::PIX_W-1:0] high_reg;
    logic                      rev_reg;
    logic [ppm_pkg::PIX_W-1:0] span_reg;
    logic                      span_ok_reg;
    logic [ppm_pkg::PIX_W:0]   span_next;
    logic                      span_ok_next;

    assign cfg_ready = 1'b1;

    assign span_next    = {high_reg[ppm_pkg::PIX_W-1], high_reg}
                        - {low_reg[ppm_pkg::PIX_W-1], low_reg};
    assign span_ok_next = !span_next[ppm_pkg::PIX_W] && (span_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg     <= ppm_pkg::LOW_RESET;
            high_reg    <= ppm_pkg::HIGH_RESET;
            rev_reg     <= 1'b0;
            span_reg    <= ppm_pkg::PIX_W'(ppm_pkg::HIGH_RESET - ppm_pkg::LOW_RESET);
            span_ok_reg <= 1'b1;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    ppm_pkg::CFG_LOW:     low_reg  <= cfg_data;
                    ppm_pkg::CFG_HIGH:    high_reg <= cfg_data;
                    ppm_pkg::CFG_REVERSE: rev_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            span_reg    <= span_next[ppm_pkg::PIX_W-1:0];
            span_ok_reg <= span_ok_next;
        end
    end

    assign cfg.high_value = high_reg;
    assign cfg.span       = span_reg;
    assign cfg.span_ok    = span_ok_reg;
    assign cfg.reverse    = rev_reg;

endmodule

@@ sv/ppm_div_stage.sv @@
// One restoring-division step of the position divider, with its own
// valid/ready stage register. Depends on ppm_pkg.
module ppm_div_stage #(
    parameter int QW = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ppm_pkg::PIX_W-1:0] in_rem,
    input  logic [QW-1:0]             in_low,
    input  logic [QW-1:0]             in_quot,
    input  ppm_pkg::ctl_t             in_ctl,
    input  logic [ppm_pkg::PIX_W-1:0] span,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ppm_pkg::PIX_W-1:0] out_rem,
    output logic [QW-1:0]             out_low,
    output logic [QW-1:0]             out_quot,
    output ppm_pkg::ctl_t             out_ctl
);

    logic                      valid_reg;
    logic [ppm_pkg::PIX_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]             low_reg, low_next;
    logic [QW-1:0]             quot_reg, quot_next;
    ppm_pkg::ctl_t             ctl_reg;
    logic [ppm_pkg::PIX_W:0]   trial;
    logic [ppm_pkg::PIX_W:0]   diff;
    logic                      ge;

    assign trial     = {in_rem, in_low[QW-1]};
    assign diff      = trial - {1'b0, span};
    assign ge        = trial >= {1'b0, span};
    assign rem_next  = ge ? diff[ppm_pkg::PIX_W-1:0] : trial[ppm_pkg::PIX_W-1:0];
    assign low_next  = {in_low[QW-2:0], 1'b0};
    assign quot_next = {in_quot[QW-2:0], ge};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quot_reg <= quot_next;
            ctl_reg  <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_quot  = quot_reg;
    assign out_ctl   = ctl_reg;

endmodule

@@ sv/ppm_ramp.sv @@
// Seven-segment color ramp: segment select stage, then color and output
// register stage. Depends on ppm_pkg.
module ppm_ramp #(
    parameter int SHADE_COUNT = 256,
    parameter int KW          = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [KW-1:0]               in_pos,
    input  ppm_pkg::ctl_t               in_ctl,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ppm_pkg::COLOR_W-1:0] red,
    output logic [ppm_pkg::COLOR_W-1:0] green,
    output logic [ppm_pkg::COLOR_W-1:0] blue,
    output logic                        at_max,
    output logic                        clamped
);

    localparam int S = SHADE_COUNT - 1;

    // segment stage
    logic          a_valid_reg;
    logic          a_ready;
    logic [KW-1:0] km1_reg, km1_next;
    logic [2:0]    seg_reg, seg_next;
    logic          dark_reg, dark_next;
    logic          a_atmax_reg;
    logic          a_clamp_reg;

    always_comb begin
        km1_next = in_pos - KW'(1);
        seg_next = 3'd0;
        for (int j = 1; j < 7; j++) begin
            if (km1_next >= KW'(j * S)) seg_next = 3'(j);
        end
        dark_next = in_ctl.black || (in_pos == '0) || (km1_next >= KW'(7 * S));
    end

    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            km1_reg     <= km1_next;
            seg_reg     <= seg_next;
            dark_reg    <= dark_next;
            a_atmax_reg <= in_ctl.at_max;
            a_clamp_reg <= in_ctl.clamp_lo || in_ctl.clamp_hi;
        end
    end

    // color stage
    logic                        b_valid_reg;
    logic [KW-1:0]               base;
    logic [ppm_pkg::COLOR_W-1:0] shade;
    logic [ppm_pkg::COLOR_W-1:0] full;
    logic [ppm_pkg::COLOR_W-1:0] red_reg, red_next;
    logic [ppm_pkg::COLOR_W-1:0] green_reg, green_next;
    logic [ppm_pkg::COLOR_W-1:0] blue_reg, blue_next;
    logic                        atmax_reg;
    logic                        clamp_reg;

    assign full  = ppm_pkg::COLOR_W'(S);
    assign base  = KW'(int'(seg_reg) * S);
    assign shade = ppm_pkg::COLOR_W'(km1_reg - base) + ppm_pkg::COLOR_W'(1);

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (!dark_reg) begin
            unique case (seg_reg)
                3'd0: blue_next = shade;
                3'd1: begin green_next = shade;        blue_next = full;         end
                3'd2: begin green_next = full;         blue_next = full - shade; end
                3'd3: begin red_next = shade;          green_next = full;        end
                3'd4: begin red_next = full;           green_next = full - shade; end
                3'd5: begin red_next = full;           blue_next = shade;        end
                3'd6: begin
                    red_next   = full;
                    green_next = shade;
                    blue_next  = full;
                end
                default: ;
            endcase
        end
    end

    assign a_ready = !b_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            atmax_reg <= a_atmax_reg;
            clamp_reg <= a_clamp_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign at_max    = atmax_reg;
    assign clamped   = clamp_reg;

endmodule

@@ sv/pseudocolor_pixel_mapper.sv @@
// Pseudocolor pixel mapper, top level.
// Input stream: one signed 32-bit pixel per transfer on s_axis_*.
// Output stream: one RGB color per pixel on m_axis_*, with flags in tuser.
// Config: write channel cfg_* (index 0 low, 1 high, 2 reverse); write only
//   while the stream is idle. cfg_ready is always high.
// Throughput: one pixel per cycle, sustained while m_axis_tready stays high.
// Stages: input register, multiply, one per quotient bit of the pipelined
//   divider, position select, segment select, color/output register.
// Every stage has its own valid bit; ready is combinational through the
//   stages, so a stalled receiver holds the output register, empty stages keep
//   filling, and s_axis_tready drops once every stage holds a pixel.
//   Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads
//   low = 0, high = 1792, reverse = 0.
// Depends on ppm_pkg, ppm_cfg_regs, ppm_div_stage, ppm_ramp and the defines header.
`include "pseudocolor_pixel_mapper_defines.svh"

module pseudocolor_pixel_mapper #(
    parameter int SHADE_COUNT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppm_pkg::PIX_W-1:0]           cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,   // [31:0] pixel_value
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // [7:0] red, [15:8] green,
                                                                // [23:16] blue
    output logic [1:0]                          m_axis_tuser    // [0] at_maximum, [1] clamped
);

    localparam int TABLE_LEN = 7 * SHADE_COUNT;
    localparam int KW        = $clog2(TABLE_LEN);
    localparam int NW        = ppm_pkg::PIX_W + KW;

    ppm_pkg::cfg_t cfg;

    ppm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    logic                      in_valid_reg;
    logic [ppm_pkg::PIX_W-1:0] pix_reg;
    logic                      mul_ready;

    assign s_axis_tready = !in_valid_reg || mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            pix_reg <= s_axis_tdata;
        end
    end

    // multiply and range classification
    logic                      mul_valid_reg;
    logic [NW-1:0]             num_reg, num_next;
    ppm_pkg::ctl_t             ctl_reg, ctl_next;
    logic [KW-1:0]             tlen;
    logic                      is_max, is_neg, is_over;
    logic                      div_in_ready;

    assign tlen     = KW'(TABLE_LEN);
    assign num_next = NW'(pix_reg[ppm_pkg::PIX_W-2:0]) * NW'(tlen);
    assign is_max   = pix_reg == cfg.high_value;
    assign is_neg   = pix_reg[ppm_pkg::PIX_W-1];
    assign is_over  = pix_reg >= cfg.span;

    always_comb begin
        ctl_next.black    = is_max || !cfg.span_ok;
        ctl_next.at_max   = is_max;
        ctl_next.clamp_lo = !ctl_next.black && is_neg;
        ctl_next.clamp_hi = !ctl_next.black && !is_neg && is_over;
    end

    assign mul_ready = !mul_valid_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid_reg) begin
            num_reg <= num_next;
            ctl_reg <= ctl_next;
        end
    end

    // pipelined restoring divider, one quotient bit per stage
    logic                      dv    [KW+1];
    logic                      dr    [KW+1];
    logic [ppm_pkg::PIX_W-1:0] drem  [KW+1];
    logic [KW-1:0]             dlow  [KW+1];
    logic [KW-1:0]             dquot [KW+1];
    ppm_pkg::ctl_t             dctl  [KW+1];
    logic                      pos_ready;

    assign dv[0]        = mul_valid_reg;
    assign div_in_ready = dr[0];
    assign drem[0]      = num_reg[NW-1:KW];
    assign dlow[0]      = num_reg[KW-1:0];
    assign dquot[0]     = '0;
    assign dctl[0]      = ctl_reg;
    assign dr[KW]       = pos_ready;

    for (genvar g = 0; g < KW; g++) begin : g_div
        ppm_div_stage #(.QW(KW)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv[g]),
            .in_ready  (dr[g]),
            .in_rem    (drem[g]),
            .in_low    (dlow[g]),
            .in_quot   (dquot[g]),
            .in_ctl    (dctl[g]),
            .span      (cfg.span),
            .out_valid (dv[g+1]),
            .out_ready (dr[g+1]),
            .out_rem   (drem[g+1]),
            .out_low   (dlow[g+1]),
            .out_quot  (dquot[g+1]),
            .out_ctl   (dctl[g+1])
        );
    end

    // position select and mirror
    logic          pos_valid_reg;
    logic [KW-1:0] pos_reg, pos_next;
    ppm_pkg::ctl_t pctl_reg;
    logic          ramp_ready;

    always_comb begin
        priority if (dctl[KW].black)    pos_next = '0;
        else if (dctl[KW].clamp_lo)     pos_next = '0;
        else if (dctl[KW].clamp_hi)     pos_next = KW'(TABLE_LEN - 1);
        else                            pos_next = dquot[KW];
        if (!dctl[KW].black && cfg.reverse) begin
            pos_next = KW'(TABLE_LEN - 1) - pos_next;
        end
    end

    assign pos_ready = !pos_valid_reg || ramp_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_valid_reg <= 1'b0;
        end else if (pos_ready) begin
            pos_valid_reg <= dv[KW];
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_ready && dv[KW]) begin
            pos_reg  <= pos_next;
            pctl_reg <= dctl[KW];
        end
    end

    // color ramp and output register
    logic [ppm_pkg::COLOR_W-1:0] red, green, blue;
    logic                        at_max, clamped;

    ppm_ramp #(.SHADE_COUNT(SHADE_COUNT), .KW(KW)) u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pos_valid_reg),
        .in_ready  (ramp_ready),
        .in_pos    (pos_reg),
        .in_ctl    (pctl_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .at_max    (at_max),
        .clamped   (clamped)
    );

    assign m_axis_tdata = {blue, green, red};
    assign m_axis_tuser = {clamped, at_max};

    // quotient in use: valid, not black, not clamped
    logic div_plain;

    assign div_plain = dv[KW] && !dctl[KW].black && !dctl[KW].clamp_lo
                     && !dctl[KW].clamp_hi;

    `PPM_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_axis_tvalid, "output valid after reset")

    `PPM_ASSERT(a_flags_exclusive, m_axis_tvalid |-> !(at_max && clamped), "at_max with clamped")

    `PPM_ASSERT(a_max_is_black, m_axis_tvalid && at_max |-> m_axis_tdata == '0, "not black")

    `PPM_ASSERT(a_div_remainder, div_plain |-> (drem[KW] < cfg.span), "remainder out of range")

endmodule
